/* rtl/core/c2mk_pkg.sv */
// ----------------------------------------------------------------------------
// c2mk_pkg
// Shared constants, codes and control structures of the multi-kernel
// convolution MAC unit.
// ----------------------------------------------------------------------------
package c2mk_pkg;

	// Store geometry
	localparam int MAX_IMAGE_DIM  = 64;
	localparam int MAX_KERNEL_DIM = 5;
	localparam int KERNELS        = 16;
	localparam int TAPS           = MAX_KERNEL_DIM * MAX_KERNEL_DIM;
	localparam int COORD_W        = $clog2(MAX_IMAGE_DIM);
	localparam int IMG_AW         = 2 * COORD_W;
	localparam int IMG_DEPTH      = MAX_IMAGE_DIM * MAX_IMAGE_DIM;
	localparam int WGT_DEPTH      = KERNELS * TAPS;
	localparam int WGT_AW         = $clog2(WGT_DEPTH);

	// Field widths
	localparam int OP_W     = 2;
	localparam int POS_W    = 7;
	localparam int KSEL_W   = 4;
	localparam int TAP_W    = 5;
	localparam int SAMPLE_W = 16;
	localparam int PROD_W   = 2 * SAMPLE_W;
	localparam int SUM_W    = 40;
	localparam int DIM_W    = 7;
	localparam int KD_W     = 3;
	localparam int SMALL_W  = 3;
	localparam int CIDX_W   = 3;
	localparam int CDATA_W  = 7;
	localparam int ORG_W    = 11;

	// Operation codes
	localparam logic [OP_W-1:0] OP_PIXEL = 2'd0;
	localparam logic [OP_W-1:0] OP_TAP   = 2'd1;
	localparam logic [OP_W-1:0] OP_CONV  = 2'd2;

	// Register indexes
	localparam logic [CIDX_W-1:0] REG_IMAGE_DIM   = 3'd0;
	localparam logic [CIDX_W-1:0] REG_KERNEL_SIDE = 3'd1;
	localparam logic [CIDX_W-1:0] REG_PAD         = 3'd2;
	localparam logic [CIDX_W-1:0] REG_STRIDE      = 3'd3;
	localparam logic [CIDX_W-1:0] REG_OUTPUT_DIM  = 3'd4;

	// Register reset values
	localparam logic [DIM_W-1:0]   RST_IMAGE_DIM   = 7'd8;
	localparam logic [KD_W-1:0]    RST_KERNEL_SIDE = 3'd3;
	localparam logic [SMALL_W-1:0] RST_PAD         = 3'd1;
	localparam logic [SMALL_W-1:0] RST_STRIDE      = 3'd1;
	localparam logic [DIM_W-1:0]   RST_OUTPUT_DIM  = 7'd8;

	// Clamp limits
	localparam logic [DIM_W-1:0] IMAGE_DIM_MAX   = DIM_W'(MAX_IMAGE_DIM);
	localparam logic [KD_W-1:0]  KERNEL_SIDE_MAX = KD_W'(MAX_KERNEL_DIM);
	localparam logic [KSEL_W:0]  KERNELS_LIM     = (KSEL_W+1)'(KERNELS);

	// Effective configuration seen by the datapath
	typedef struct packed {
		logic [DIM_W-1:0]   image_dim;
		logic [KD_W-1:0]    kernel_side;
		logic [SMALL_W-1:0] pad_amount;
		logic [SMALL_W-1:0] stride_step;
		logic [DIM_W-1:0]   output_dim;
	} cfg_t;

	// Controller to datapath
	typedef struct packed {
		logic take;
		logic check;
		logic step;
		logic load_out;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic item_ok;
		logic is_conv;
		logic window_empty;
		logic last_step;
		logic busy;
		logic out_free;
	} sts_t;

endpackage

/* rtl/core/c2mk_ctrl.sv */
// ----------------------------------------------------------------------------
// c2mk_ctrl
// Sequencer: takes one word, checks it, walks the kernel window for a valid
// compute, then hands the result to the output register.
// ----------------------------------------------------------------------------
module c2mk_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  c2mk_pkg::sts_t  sts,
	output c2mk_pkg::cmd_t  cmd
);
	import c2mk_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CHECK,
		S_RUN,
		S_FINISH
	} state_t;

	state_t state_q;
	logic   in_ready_q;
	logic   take;

	assign take     = in_valid && in_ready_q;
	assign in_ready = in_ready_q;

	always_comb begin
		cmd          = '0;
		cmd.take     = take;
		cmd.check    = (state_q == S_CHECK);
		cmd.step     = (state_q == S_RUN);
		cmd.load_out = (state_q == S_FINISH) && !sts.busy && sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			in_ready_q <= 1'b1;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (take) begin
						state_q    <= S_CHECK;
						in_ready_q <= 1'b0;
					end
				end
				S_CHECK: begin
					if (sts.item_ok && sts.is_conv && !sts.window_empty)
						state_q <= S_RUN;
					else
						state_q <= S_FINISH;
				end
				S_RUN: begin
					if (sts.last_step)
						state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (!sts.busy && sts.out_free) begin
						state_q    <= S_IDLE;
						in_ready_q <= 1'b1;
					end
				end
				default: begin
					state_q    <= S_IDLE;
					in_ready_q <= 1'b1;
				end
			endcase
		end
	end

endmodule

/* rtl/core/c2mk_dp.sv */
// ----------------------------------------------------------------------------
// c2mk_dp
// Datapath: image and weight stores, window address walk, one pipelined
// multiply-accumulate and the output register.
// ----------------------------------------------------------------------------
module c2mk_dp (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  c2mk_pkg::cfg_t                          cfg,
	input  c2mk_pkg::cmd_t                          cmd,
	output c2mk_pkg::sts_t                          sts,
	input  logic [c2mk_pkg::OP_W-1:0]               operation,
	input  logic [c2mk_pkg::POS_W-1:0]              position_y,
	input  logic [c2mk_pkg::POS_W-1:0]              position_x,
	input  logic [c2mk_pkg::KSEL_W-1:0]             kernel_select,
	input  logic [c2mk_pkg::TAP_W-1:0]              tap_index,
	input  logic signed [c2mk_pkg::SAMPLE_W-1:0]    sample_value,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic signed [c2mk_pkg::SUM_W-1:0]       conv_sum,
	output logic                                    status
);
	import c2mk_pkg::*;

	logic [SAMPLE_W-1:0] image_mem [IMG_DEPTH];
	logic [SAMPLE_W-1:0] weight_mem [WGT_DEPTH];

	// Held word
	logic [OP_W-1:0]            op_q;
	logic [POS_W-1:0]           py_q;
	logic [POS_W-1:0]           px_q;
	logic [KSEL_W-1:0]          ks_q;
	logic [TAP_W-1:0]           tap_q;
	logic signed [SAMPLE_W-1:0] val_q;

	// Window walk
	logic                       err_q;
	logic signed [ORG_W-1:0]    y0_q;
	logic signed [ORG_W-1:0]    x0_q;
	logic [WGT_AW-1:0]          wbase_q;
	logic [KD_W-1:0]            row_q;
	logic [KD_W-1:0]            col_q;
	logic [TAP_W-1:0]           toff_q;

	// MAC pipeline
	logic                       vld_s1;
	logic                       hit_s1;
	logic [SAMPLE_W-1:0]        img_s1;
	logic [SAMPLE_W-1:0]        wgt_s1;
	logic                       vld_s2;
	logic signed [PROD_W-1:0]   prod_s2;
	logic signed [SUM_W-1:0]    acc_q;

	logic                       out_valid_q;
	logic signed [SUM_W-1:0]    out_sum_q;
	logic                       out_status_q;

	logic                       ks_ok;
	logic                       pix_ok;
	logic                       tap_ok;
	logic                       conv_ok;
	logic                       item_ok;
	logic [5:0]                 kk;
	logic [9:0]                 sy;
	logic [9:0]                 sx;
	logic signed [ORG_W-1:0]    y0_n;
	logic signed [ORG_W-1:0]    x0_n;
	logic signed [ORG_W-1:0]    iy;
	logic signed [ORG_W-1:0]    ix;
	logic [ORG_W-1:0]           idim_w;
	logic                       hit;
	logic [KD_W-1:0]            kd_last;
	logic                       col_end;
	logic [IMG_AW-1:0]          img_rd_addr;
	logic [IMG_AW-1:0]          img_wr_addr;
	logic [WGT_AW-1:0]          wgt_rd_addr;
	logic [WGT_AW-1:0]          wgt_wr_addr;

	// Range checks
	assign kk      = 6'(cfg.kernel_side) * 6'(cfg.kernel_side);
	assign ks_ok   = {1'b0, ks_q} < KERNELS_LIM;
	assign pix_ok  = (py_q < cfg.image_dim) && (px_q < cfg.image_dim);
	assign tap_ok  = ks_ok && ({1'b0, tap_q} < kk);
	assign conv_ok = ks_ok && (py_q < cfg.output_dim) && (px_q < cfg.output_dim);

	always_comb begin
		case (op_q)
			OP_PIXEL: item_ok = pix_ok;
			OP_TAP:   item_ok = tap_ok;
			OP_CONV:  item_ok = conv_ok;
			default:  item_ok = 1'b0;
		endcase
	end

	// Window origin: stride * position - pad
	assign sy   = 10'(cfg.stride_step) * 10'(py_q);
	assign sx   = 10'(cfg.stride_step) * 10'(px_q);
	assign y0_n = $signed({1'b0, sy}) - $signed(ORG_W'(cfg.pad_amount));
	assign x0_n = $signed({1'b0, sx}) - $signed(ORG_W'(cfg.pad_amount));

	// Current tap: drop it when it lands in the padding on any edge
	assign iy      = y0_q + $signed(ORG_W'(row_q));
	assign ix      = x0_q + $signed(ORG_W'(col_q));
	assign idim_w  = ORG_W'(cfg.image_dim);
	assign hit     = !iy[ORG_W-1] && !ix[ORG_W-1]
	                 && (unsigned'(iy) < idim_w) && (unsigned'(ix) < idim_w);
	assign kd_last = cfg.kernel_side - KD_W'(1);
	assign col_end = (col_q == kd_last);

	assign img_rd_addr = {iy[COORD_W-1:0], ix[COORD_W-1:0]};
	assign img_wr_addr = {py_q[COORD_W-1:0], px_q[COORD_W-1:0]};
	assign wgt_rd_addr = wbase_q + WGT_AW'(toff_q);
	assign wgt_wr_addr = WGT_AW'(ks_q * TAPS) + WGT_AW'(tap_q);

	always_comb begin
		sts              = '0;
		sts.item_ok      = item_ok;
		sts.is_conv      = (op_q == OP_CONV);
		sts.window_empty = (cfg.kernel_side == '0);
		sts.last_step    = col_end && (row_q == kd_last);
		sts.busy         = vld_s1 || vld_s2;
		sts.out_free     = !out_valid_q || out_ready;
	end

	// Capture the word on accept
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			op_q  <= operation;
			py_q  <= position_y;
			px_q  <= position_x;
			ks_q  <= kernel_select;
			tap_q <= tap_index;
			val_q <= sample_value;
		end
	end

	// Stores: write during the check cycle, read while walking
	always_ff @(posedge clk) begin
		if (cmd.check && (op_q == OP_PIXEL) && pix_ok)
			image_mem[img_wr_addr] <= val_q;
		if (cmd.step)
			img_s1 <= image_mem[img_rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.check && (op_q == OP_TAP) && tap_ok)
			weight_mem[wgt_wr_addr] <= val_q;
		if (cmd.step)
			wgt_s1 <= weight_mem[wgt_rd_addr];
	end

	// Walk counters and accumulator
	always_ff @(posedge clk) begin
		if (cmd.check) begin
			err_q   <= !item_ok;
			y0_q    <= y0_n;
			x0_q    <= x0_n;
			wbase_q <= WGT_AW'(ks_q * TAPS);
			row_q   <= '0;
			col_q   <= '0;
			toff_q  <= '0;
		end else if (cmd.step) begin
			toff_q <= toff_q + TAP_W'(1);
			if (col_end) begin
				col_q <= '0;
				row_q <= row_q + KD_W'(1);
			end else begin
				col_q <= col_q + KD_W'(1);
			end
		end
		hit_s1  <= hit;
		prod_s2 <= hit_s1 ? $signed(wgt_s1) * $signed(img_s1) : $signed(PROD_W'(0));
		if (cmd.check)
			acc_q <= '0;
		else if (vld_s2)
			acc_q <= acc_q + SUM_W'(prod_s2);
		if (cmd.load_out) begin
			out_sum_q    <= acc_q;
			out_status_q <= err_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			vld_s1 <= cmd.step;
			vld_s2 <= vld_s1;
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign conv_sum  = out_sum_q;
	assign status    = out_status_q;

endmodule

/* rtl/core/conv2d_multi_kernel_mac_unit.sv */
// Flow: a pixel or tap write is accepted, checked and stored, then its result word goes
// to the output register; a compute also walks kd*kd taps (kd = clamped kernel side).
// A new word is not taken until the previous one has reached the output register;
// a compute is paced by the single multiply-accumulate that walks one tap a cycle.
// A new word is taken while the previous result still waits in the output register.
// Reset (arst_n low) clears control and loads register defaults; stores are not cleared.
// ----------------------------------------------------------------------------
// conv2d_multi_kernel_mac_unit
// Single-channel 2D convolution with zero padding and stride over a set of
// square kernels held in on-chip stores.
// ----------------------------------------------------------------------------
module conv2d_multi_kernel_mac_unit (
	input  logic                                    clk,
	input  logic                                    arst_n,
	// Item channel
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic [c2mk_pkg::OP_W-1:0]               operation,
	input  logic [c2mk_pkg::POS_W-1:0]              position_y,
	input  logic [c2mk_pkg::POS_W-1:0]              position_x,
	input  logic [c2mk_pkg::KSEL_W-1:0]             kernel_select,
	input  logic [c2mk_pkg::TAP_W-1:0]              tap_index,
	input  logic signed [c2mk_pkg::SAMPLE_W-1:0]    sample_value,
	// Result channel
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic signed [c2mk_pkg::SUM_W-1:0]       conv_sum,
	output logic                                    status,
	// Configuration channel
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [c2mk_pkg::CIDX_W-1:0]             cfg_index,
	input  logic [c2mk_pkg::CDATA_W-1:0]            cfg_data
);
	import c2mk_pkg::*;

	// Raw register file, written as given
	logic [DIM_W-1:0]   image_dim_q;
	logic [KD_W-1:0]    kernel_side_q;
	logic [SMALL_W-1:0] pad_amount_q;
	logic [SMALL_W-1:0] stride_step_q;
	logic [DIM_W-1:0]   output_dim_q;

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;

	// Configuration writes are always taken; an index past the list is dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_dim_q   <= RST_IMAGE_DIM;
			kernel_side_q <= RST_KERNEL_SIDE;
			pad_amount_q  <= RST_PAD;
			stride_step_q <= RST_STRIDE;
			output_dim_q  <= RST_OUTPUT_DIM;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_IMAGE_DIM:   image_dim_q   <= cfg_data[DIM_W-1:0];
				REG_KERNEL_SIDE: kernel_side_q <= cfg_data[KD_W-1:0];
				REG_PAD:         pad_amount_q  <= cfg_data[SMALL_W-1:0];
				REG_STRIDE:      stride_step_q <= cfg_data[SMALL_W-1:0];
				REG_OUTPUT_DIM:  output_dim_q  <= cfg_data[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamp the image and kernel sides to what the stores hold; zero stays
	// zero, so an empty image or empty window falls out naturally.
	always_comb begin
		cfg             = '0;
		cfg.image_dim   = (image_dim_q > IMAGE_DIM_MAX) ? IMAGE_DIM_MAX : image_dim_q;
		cfg.kernel_side = (kernel_side_q > KERNEL_SIDE_MAX) ? KERNEL_SIDE_MAX
			: kernel_side_q;
		cfg.pad_amount  = pad_amount_q;
		cfg.stride_step = stride_step_q;
		cfg.output_dim  = output_dim_q;
	end

	// Sequencer: accept, check, walk, hand over
	c2mk_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Stores, MAC pipeline and output register
	c2mk_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.cmd           (cmd),
		.sts           (sts),
		.operation     (operation),
		.position_y    (position_y),
		.position_x    (position_x),
		.kernel_select (kernel_select),
		.tap_index     (tap_index),
		.sample_value  (sample_value),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.conv_sum      (conv_sum),
		.status        (status)
	);

	// Hold off new words for at least the cycle after an accept.
	a_accept_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("word accepted on two consecutive cycles");

	// A result is loaded only from the hand-over step, never while idle.
	a_load_not_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared while the sequencer was idle");

	// A rejected word carries a zero sum.
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> conv_sum == '0)
		else $error("rejected word with non-zero sum");

endmodule
